/* hw/rtl/tws_pkg.sv */
// ---------------------------------------------------------------------------
// tws_pkg: shared types and constants of the trie word store
// Node table geometry, row layout, command codes and the control structs
// passed between the controller and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  // Tree geometry
  localparam int MAX_NODES = 1024;
  localparam int ALPHABET  = 26;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int LIDX_W    = $clog2(ALPHABET);
  localparam int LETTER_W  = 5;

  // Command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ALPHABET-1:0][NODE_W-1:0] kids_t;

  // One table row per node: its word mark above all child pointers
  typedef struct packed {
    logic  mark;
    kids_t kids;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Row memory access issued by the controller
  typedef struct packed {
    logic  we;
    node_t waddr;
    row_t  wdata;
    logic  re;
    node_t raddr;
  } mem_req_t;

  // Result of one terminated word
  typedef struct packed {
    logic valid;
    logic found_prefix;
    logic found_word;
    logic pool_full;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/tws_ram.sv */
// ---------------------------------------------------------------------------
// tws_ram: synchronous row memory with separate write and read ports
// One write and one read port, read data registered on a read enable.
// ---------------------------------------------------------------------------
`default_nettype none

module tws_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tws_ctrl.sv */
// ---------------------------------------------------------------------------
// tws_ctrl: walk controller of the trie word store
// Clears the node table after reset, then walks one letter per transaction
// with a row read followed by an optional write back.
// ---------------------------------------------------------------------------
`default_nettype none

module tws_ctrl
  import tws_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_cmd,
  input  wire logic [LETTER_W-1:0] in_letter,
  input  wire logic                in_has_letter,
  output logic                     in_ready,
  input  wire logic                out_free,
  input  wire row_t                rd_row,
  output mem_req_t                 mem_req,
  output res_t                     res
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  state_t              state_r, state_nxt;
  node_t               clr_addr_r, clr_addr_nxt;
  node_t               cursor_r, cursor_nxt;
  cnt_t                used_r, used_nxt;
  logic                missed_r, missed_nxt;
  logic                overflow_r, overflow_nxt;
  logic                cmd_r, cmd_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  logic                has_r, has_nxt;

  logic                accept;
  logic                dead;
  logic                bad_letter;
  logic [LIDX_W-1:0]   lidx;
  node_t               kid;
  row_t                wrow;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign dead       = missed_r || overflow_r;
  assign bad_letter = (32'(in_letter) >= ALPHABET);
  assign lidx       = LIDX_W'(letter_r);
  assign kid        = rd_row.kids[lidx];

  // Next state, memory requests and result
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cursor_nxt   = cursor_r;
    used_nxt     = used_r;
    missed_nxt   = missed_r;
    overflow_nxt = overflow_r;
    cmd_nxt      = cmd_r;
    letter_nxt   = letter_r;
    has_nxt      = has_r;
    wrow         = rd_row;
    mem_req      = '0;
    res          = '0;

    case (state_r)
      ST_CLEAR: begin
        // Sweep zero rows through the table
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
        mem_req.wdata = '0;
        clr_addr_nxt  = clr_addr_r + 1'b1;
        if (clr_addr_r == NODE_W'(MAX_NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd;
          letter_nxt = in_letter;
          has_nxt    = in_has_letter;
          if (in_has_letter && (dead || bad_letter)) begin
            // Walk stays put; an unknown letter is a missing branch
            if (!dead) begin
              missed_nxt = 1'b1;
            end
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = cursor_r;
            state_nxt     = ST_READ;
          end
        end
      end

      ST_READ: begin
        if (has_r) begin
          // Follow or allocate the child branch
          state_nxt = ST_IDLE;
          if (kid != '0) begin
            cursor_nxt = kid;
          end else if (cmd_r == CMD_QUERY) begin
            missed_nxt = 1'b1;
          end else if (used_r >= CNT_W'(MAX_NODES)) begin
            overflow_nxt = 1'b1;
          end else begin
            wrow.kids[lidx] = used_r[NODE_W-1:0];
            mem_req.we      = 1'b1;
            mem_req.waddr   = cursor_r;
            mem_req.wdata   = wrow;
            cursor_nxt      = used_r[NODE_W-1:0];
            used_nxt        = used_r + 1'b1;
          end
        end else if (out_free) begin
          // Close the word: mark on add, report, return to root
          state_nxt = ST_IDLE;
          res.valid = 1'b1;
          if (cmd_r == CMD_ADD) begin
            res.found_prefix = 1'b1;
            res.found_word   = !dead;
            res.pool_full    = overflow_r;
            if (!dead) begin
              wrow.mark     = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.waddr = cursor_r;
              mem_req.wdata = wrow;
            end
          end else begin
            res.found_prefix = !dead;
            res.found_word   = !dead && rd_row.mark;
            res.pool_full    = 1'b0;
          end
          cursor_nxt   = '0;
          missed_nxt   = 1'b0;
          overflow_nxt = 1'b0;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State and walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      cursor_r   <= '0;
      used_r     <= CNT_W'(1);
      missed_r   <= 1'b0;
      overflow_r <= 1'b0;
      cmd_r      <= CMD_ADD;
      letter_r   <= '0;
      has_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cursor_r   <= cursor_nxt;
      used_r     <= used_nxt;
      missed_r   <= missed_nxt;
      overflow_r <= overflow_nxt;
      cmd_r      <= cmd_nxt;
      letter_r   <= letter_nxt;
      has_r      <= has_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/trie_word_store.sv */
// ---------------------------------------------------------------------------
// trie_word_store: prefix tree word store with add and query
// Stores words over a 26-letter alphabet in a node table and answers
// prefix and word queries, one result per terminated word.
// ---------------------------------------------------------------------------
// After reset the block sweeps the node table clear, one node row per cycle;
// in_tready stays low until that pass ends. For each item the cursor
// node's row is read from the table memory and, in the read state, written
// back when a child is allocated or a word is marked; in_tready stays low
// until the item is done. A letter item arriving after the walk already
// failed, or with a code above z, needs no row read. A terminator waits
// while the previous result still sits unclaimed in the output register.
// Letters stream in with in_tuser[1] high; an item with in_tuser[1] low ends
// the word, and its in_tuser[0] selects add (0) or query (1).
`default_nettype none

module trie_word_store
  import tws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [4:0] letter, [7:5] zero
  input  wire logic [1:0] in_tuser,   // [0] cmd, [1] has_letter
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] found_prefix, [1] found_word,
                                      // [2] pool_full, [7:3] zero
);

  mem_req_t mem_req;
  res_t     res;
  row_t     rd_row;
  logic     out_valid_r;
  logic     out_free;
  logic [2:0] out_flags_r;

  assign out_free = !out_valid_r || out_tready;

  tws_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_cmd       (in_tuser[0]),
    .in_letter    (in_tdata[LETTER_W-1:0]),
    .in_has_letter(in_tuser[1]),
    .in_ready     (in_tready),
    .out_free     (out_free),
    .rd_row       (rd_row),
    .mem_req      (mem_req),
    .res          (res)
  );

  tws_ram #(
    .DEPTH(MAX_NODES),
    .WIDTH(ROW_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(rd_row)
  );

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_flags_r <= {res.pool_full, res.found_word, res.found_prefix};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_flags_r};

`ifndef SYNTHESIS
  // A new result only lands in a free output register
  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid_r || out_tready))
    else $error("result issued while output register busy");

  // Table reads and write backs never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("table read and write in the same cycle");

  // A row read blocks intake until its data is used
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.re |=> !in_tready)
    else $error("input accepted while a row read was pending");
`endif

endmodule

`default_nettype wire

/* sim/trie_word_checker.sv */
// ---------------------------------------------------------------------------
// trie_word_checker: scoreboard for the trie word store
// Watches both stream channels, runs its own prefix tree on every accepted
// input transaction and compares each result transaction against the
// oldest predicted answer, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module trie_word_checker
  import tws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [4:0] letter, [7:5] zero
  input  wire logic [1:0] in_tuser,   // [0] cmd, [1] has_letter
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,  // [0] found_prefix, [1] found_word,
                                      // [2] pool_full, [7:3] zero
  output int              fail_count,
  output int              answers_pending
);

  typedef struct packed {
    logic found_prefix;
    logic found_word;
    logic pool_full;
  } answer_t;

  // Model of the tree: child pointers, word marks and walk state
  node_t   kid_tab [MAX_NODES][ALPHABET];
  logic    word_end [MAX_NODES];
  cnt_t    nodes_taken;
  node_t   cur_node;
  logic    branch_missed;
  logic    pool_ran_out;
  answer_t answer_q [$];

  // Advance the tree by one item; a terminator queues its answer
  task automatic walk_item(input logic cmd, input logic [4:0] code, input logic is_letter);
    node_t   nxt;
    logic    reached;
    answer_t ans;
    if (is_letter) begin
      if (!branch_missed && !pool_ran_out) begin
        if (int'(code) >= ALPHABET) begin
          branch_missed = 1'b1;
        end else begin
          nxt = kid_tab[cur_node][code];
          if (nxt == '0) begin
            if (cmd == CMD_QUERY) begin
              branch_missed = 1'b1;
            end else if (int'(nodes_taken) >= MAX_NODES) begin
              pool_ran_out = 1'b1;
            end else begin
              nxt = node_t'(nodes_taken);
              nodes_taken = nodes_taken + 1'b1;
              kid_tab[cur_node][code] = nxt;
            end
          end
          if (!branch_missed && !pool_ran_out) cur_node = nxt;
        end
      end
    end else begin
      reached = !branch_missed && !pool_ran_out;
      if (cmd == CMD_ADD) begin
        if (reached) word_end[cur_node] = 1'b1;
        ans.found_prefix = 1'b1;
        ans.found_word   = reached;
        ans.pool_full    = pool_ran_out;
      end else begin
        ans.found_prefix = reached;
        ans.found_word   = reached && word_end[cur_node];
        ans.pool_full    = 1'b0;
      end
      answer_q.push_back(ans);
      cur_node      = '0;
      branch_missed = 1'b0;
      pool_ran_out  = 1'b0;
    end
  endtask

  task automatic compare_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Clear the model in reset, then score every transaction
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      for (int n = 0; n < MAX_NODES; n++) begin
        word_end[n] = 1'b0;
        for (int k = 0; k < ALPHABET; k++) kid_tab[n][k] = '0;
      end
      nodes_taken   = cnt_t'(1);
      cur_node      = '0;
      branch_missed = 1'b0;
      pool_ran_out  = 1'b0;
      fail_count    = 0;
      answer_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          $error("result transaction with no answer pending: out_tdata=%h", out_tdata);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          compare_field("found_prefix", want.found_prefix, out_tdata[0]);
          compare_field("found_word", want.found_word, out_tdata[1]);
          compare_field("pool_full", want.pool_full, out_tdata[2]);
        end
      end
      if (in_tvalid && in_tready) walk_item(in_tuser[0], in_tdata[4:0], in_tuser[1]);
    end
    answers_pending = answer_q.size();
  end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: testbench top for the trie word store
// Drives directed and random words of letter transactions through the
// block under varying sender and receiver idling, lets the checker score
// the results, and reports the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top
  import tws_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int BUF_DEPTH      = 128;
  localparam int ITEM_TARGET    = 1300;

  // Idling phases
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;   // [4:0] letter, [7:5] zero
  logic [1:0] in_tuser   = '0;   // [0] cmd, [1] has_letter
  logic       out_tvalid;
  logic       out_tready = 1'b1;
  logic [7:0] out_tdata;         // [0] found_prefix, [1] found_word, [2] pool_full

  int fail_count;
  int answers_pending;

  int idle_mode   = IDLE_NONE;
  int items_sent  = 0;
  int words_sent  = 0;
  int quiet_ticks = 0;

  // Current word: per-letter command and code
  logic [4:0] word_buf [BUF_DEPTH];
  logic       word_cmd [BUF_DEPTH];

  // Random fresh-add words so far, kept for later queries and re-adds
  logic [4:0] bank_letters [$];
  int         bank_start [$];
  int         bank_len [$];

  trie_word_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  trie_word_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .answers_pending (answers_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel according to the phase
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_tready <= ($urandom_range(0, 99) >= 67);
      IDLE_BOTH: out_tready <= ($urandom_range(0, 99) >= 29);
      default:   out_tready <= 1'b1;
    endcase
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_ticks <= 0;
      else quiet_ticks <= quiet_ticks + 1;
      if (quiet_ticks >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 67;
      IDLE_BOTH: return $urandom_range(0, 99) < 29;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic [4:0] rand_code(input bit allow_bad);
    if (allow_bad && $urandom_range(0, 29) == 0) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(0, 25));
  endfunction

  // Send one transaction; entered and left at a falling edge
  task automatic send_item(input logic cmd, input logic [4:0] code, input logic has_letter);
    while (sender_idles()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, code};
    in_tuser  <= {has_letter, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Send the letters of word_buf and close them with a terminator
  task automatic send_word(input logic term_cmd, input int len);
    for (int i = 0; i < len; i++) send_item(word_cmd[i], word_buf[i], 1'b1);
    send_item(term_cmd, 5'd0, 1'b0);
    words_sent++;
    idle_mode = (words_sent / 16) % 4;
  endtask

  task automatic set_letter(input int idx, input logic cmd, input logic [4:0] code);
    word_buf[idx] = code;
    word_cmd[idx] = cmd;
  endtask

  task automatic fill_cmd(input logic cmd, input int len);
    for (int i = 0; i < len; i++) word_cmd[i] = cmd;
  endtask

  // Copy a stored word into word_buf, returning its length
  task automatic load_bank_word(output int len);
    int idx;
    idx = $urandom_range(0, bank_len.size() - 1);
    len = bank_len[idx];
    for (int i = 0; i < len; i++) word_buf[i] = bank_letters[bank_start[idx] + i];
  endtask

  task automatic remember_word(input int len);
    if (len == 0) return;
    bank_start.push_back(bank_letters.size());
    bank_len.push_back(len);
    for (int i = 0; i < len; i++) bank_letters.push_back(word_buf[i]);
  endtask

  // Directed words: empty word, prefix queries, misses, bad codes, mixed commands
  task automatic run_directed();
    send_word(CMD_QUERY, 0);                 // empty tree, empty query
    send_word(CMD_ADD, 0);                   // mark the root
    send_word(CMD_QUERY, 0);
    set_letter(0, CMD_ADD, 5'd0);            // add "az"
    set_letter(1, CMD_ADD, 5'd25);
    send_word(CMD_ADD, 2);
    set_letter(0, CMD_QUERY, 5'd0);          // prefix only
    send_word(CMD_QUERY, 1);
    set_letter(0, CMD_QUERY, 5'd0);          // full word
    set_letter(1, CMD_QUERY, 5'd25);
    send_word(CMD_QUERY, 2);
    set_letter(0, CMD_QUERY, 5'd25);         // missing branch
    set_letter(1, CMD_QUERY, 5'd0);
    send_word(CMD_QUERY, 2);
    set_letter(0, CMD_ADD, 5'd31);           // code above z, then a letter after the miss
    set_letter(1, CMD_ADD, 5'd0);
    send_word(CMD_ADD, 2);
    set_letter(0, CMD_QUERY, 5'd26);
    send_word(CMD_QUERY, 1);
    set_letter(0, CMD_ADD, 5'd1);            // add letter, then a query letter that misses
    set_letter(1, CMD_QUERY, 5'd2);
    send_word(CMD_ADD, 2);
    set_letter(0, CMD_ADD, 5'd24);           // add letter closed by a query
    send_word(CMD_QUERY, 1);
  endtask

  // One random word of a random kind
  task automatic run_random_word();
    int   kind;
    int   len;
    logic term_cmd;
    kind = $urandom_range(0, 99);
    if (bank_len.size() == 0 && kind >= 40 && kind < 80) kind = 0;
    if (kind < 40) begin
      // fresh add, sometimes long enough to drain the pool
      if ($urandom_range(0, 5) == 0) len = $urandom_range(40, 110);
      else len = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) word_buf[i] = rand_code(1'b1);
      fill_cmd(CMD_ADD, len);
      term_cmd = CMD_ADD;
      remember_word(len);
    end else if (kind < 55) begin
      // re-add a stored word or one of its prefixes
      load_bank_word(len);
      if ($urandom_range(0, 2) == 0) len = $urandom_range(0, len);
      fill_cmd(CMD_ADD, len);
      term_cmd = CMD_ADD;
    end else if (kind < 80) begin
      // query a stored word, a prefix of it, or an extension
      load_bank_word(len);
      case ($urandom_range(0, 2))
        0: len = $urandom_range(0, len);
        1: if (len < BUF_DEPTH) begin
          word_buf[len] = rand_code(1'b0);
          len++;
        end
        default: ;
      endcase
      fill_cmd(CMD_QUERY, len);
      term_cmd = CMD_QUERY;
    end else if (kind < 92) begin
      // query of random letters
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) word_buf[i] = rand_code(1'b1);
      fill_cmd(CMD_QUERY, len);
      term_cmd = CMD_QUERY;
    end else begin
      // noise: commands mixed per letter, any code
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        word_buf[i] = 5'($urandom_range(0, 31));
        word_cmd[i] = logic'($urandom_range(0, 1));
      end
      term_cmd = logic'($urandom_range(0, 1));
    end
    send_word(term_cmd, len);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    while (items_sent < ITEM_TARGET) run_random_word();

    // Drain with the receiver always ready
    in_tvalid <= 1'b0;
    idle_mode = IDLE_NONE;
    while (answers_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
